>>> rtl/spp_pkg.sv
// ----------------------------------------------------------------------------
// spp_pkg - shared types and constants of the strong probable prime tester
// Datapath width, widths of the external fields, sequencer states,
// modular-multiplier opcodes and the status structs passed between modules.
// ----------------------------------------------------------------------------
package spp_pkg;

	// datapath width (8..32); operands are cut to this many low bits
	localparam int NUM_WIDTH = 32;

	// external field widths
	localparam int CAND_W = 32;
	localparam int BASE_W = 32;

	// counter widths
	localparam int CNT_W = $clog2(NUM_WIDTH + 1);
	localparam int S_W   = $clog2(NUM_WIDTH);

	localparam logic [NUM_WIDTH-1:0] NUM_ONE    = NUM_WIDTH'(1);
	localparam logic [BASE_W-1:0]    BASE_RESET = BASE_W'(2);

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TZ,
		ST_GO,
		ST_WAIT,
		ST_EXP,
		ST_CHK,
		ST_DONE
	} spp_state_t;

	// what the modular multiplier is doing for the sequencer
	typedef enum logic [1:0] {
		OP_RED,
		OP_SQ,
		OP_MUL,
		OP_CHK
	} spp_op_t;

	// multiplier status towards the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} spp_mm_stat_t;

	// verdict towards the output register
	typedef struct packed {
		logic push;
		logic flag;
	} spp_res_t;

endpackage

>>> rtl/spp_if.sv
// ----------------------------------------------------------------------------
// spp_if - channel interfaces of the strong probable prime tester
// Request channel, response channel and base register write channel,
// each with valid/ready and a source and a sink modport.
// ----------------------------------------------------------------------------
interface spp_cand_if
	import spp_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [CAND_W-1:0] candidate;

	modport source (output valid, output candidate, input ready);
	modport sink   (input valid, input candidate, output ready);
endinterface

interface spp_res_if;
	logic valid;
	logic ready;
	logic probable_prime;

	modport source (output valid, output probable_prime, input ready);
	modport sink   (input valid, input probable_prime, output ready);
endinterface

interface spp_cfg_if
	import spp_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BASE_W-1:0] witness_base;

	modport source (output valid, output witness_base, input ready);
	modport sink   (input valid, input witness_base, output ready);
endinterface

>>> rtl/spp_modmul.sv
// ----------------------------------------------------------------------------
// spp_modmul - bit-serial modular multiplier
// Computes x * y mod n by interleaved shift-and-add, one bit of y per cycle,
// most significant first. Needs x < n; y may be any value.
// ----------------------------------------------------------------------------
module spp_modmul
	import spp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [NUM_WIDTH-1:0] op_x,
	input  logic [NUM_WIDTH-1:0] op_y,
	input  logic [NUM_WIDTH-1:0] modulus,
	output logic [NUM_WIDTH-1:0] product,
	output spp_mm_stat_t         stat
);

	logic [NUM_WIDTH-1:0] r_q;
	logic [NUM_WIDTH-1:0] x_q;
	logic [NUM_WIDTH-1:0] y_q;
	logic [NUM_WIDTH-1:0] n_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [NUM_WIDTH:0]   dbl;
	logic [NUM_WIDTH+1:0] dbl_sub;
	logic [NUM_WIDTH-1:0] dbl_red;
	logic [NUM_WIDTH:0]   acc;
	logic [NUM_WIDTH+1:0] acc_sub;
	logic [NUM_WIDTH-1:0] r_next;

	// double the residue and reduce, then add x when the y bit is set and reduce
	always_comb begin
		dbl     = {r_q, 1'b0};
		dbl_sub = {1'b0, dbl} - {2'b00, n_q};
		dbl_red = dbl_sub[NUM_WIDTH+1] ? dbl[NUM_WIDTH-1:0] : dbl_sub[NUM_WIDTH-1:0];
		acc     = {1'b0, dbl_red} + {1'b0, (y_q[NUM_WIDTH-1] ? x_q : '0)};
		acc_sub = {1'b0, acc} - {2'b00, n_q};
		r_next  = acc_sub[NUM_WIDTH+1] ? acc[NUM_WIDTH-1:0] : acc_sub[NUM_WIDTH-1:0];
	end

	// load operands, then advance one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(NUM_WIDTH);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= '0;
			x_q <= op_x;
			y_q <= op_y;
			n_q <= modulus;
		end else if (busy_q) begin
			r_q <= r_next;
			y_q <= {y_q[NUM_WIDTH-2:0], 1'b0};
		end
	end

	assign product   = r_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	// the residue stays reduced once a product is out
	a_done_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (r_q < n_q))
		else $error("modmul residue not below modulus");

	// done follows the last step and lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q || $past(start))
		else $error("modmul done held");

endmodule

>>> rtl/spp_ctrl.sv
// ----------------------------------------------------------------------------
// spp_ctrl - sequencer of the strong probable prime test
// Splits n-1 into d * 2^s, reduces the base, runs left-to-right
// square-and-multiply over d and the squaring chain, all on one multiplier.
// ----------------------------------------------------------------------------
module spp_ctrl
	import spp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic [CAND_W-1:0] cand,
	input  logic [BASE_W-1:0] base,
	input  logic              out_free,
	output spp_res_t          res
);

	spp_state_t state_q, state_d;
	spp_op_t    op_q;

	logic [NUM_WIDTH-1:0] n_q;
	logic [NUM_WIDTH-1:0] a_q;
	logic [NUM_WIDTH-1:0] base_q;
	logic [NUM_WIDTH-1:0] x_q;
	logic [NUM_WIDTH-1:0] e_q;
	logic [CNT_W-1:0]     ecnt_q;
	logic [S_W-1:0]       s_q;
	logic                 started_q;
	logic                 flag_q;

	logic [NUM_WIDTH-1:0] nm1;
	logic [NUM_WIDTH-1:0] cand_n;
	logic                 req_fire;
	logic                 cand_small;
	logic                 mm_start;
	logic [NUM_WIDTH-1:0] mm_x;
	logic [NUM_WIDTH-1:0] mm_y;
	logic [NUM_WIDTH-1:0] mm_r;
	spp_mm_stat_t         mm_stat;

	assign cand_n     = cand[NUM_WIDTH-1:0];
	assign cand_small = (cand_n[NUM_WIDTH-1:1] == '0);
	assign nm1        = n_q - NUM_ONE;
	assign req_fire   = req_valid && req_ready;

	// shared modular multiplier
	spp_modmul u_modmul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mm_start),
		.op_x    (mm_x),
		.op_y    (mm_y),
		.modulus (n_q),
		.product (mm_r),
		.stat    (mm_stat)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_fire) state_d = cand_small ? ST_DONE : ST_TZ;
			end
			ST_TZ: begin
				if (e_q[0]) state_d = ST_GO;
			end
			ST_GO: begin
				state_d = ST_WAIT;
			end
			ST_WAIT: begin
				if (mm_stat.done) begin
					case (op_q)
						OP_SQ:   state_d = e_q[NUM_WIDTH-1] ? ST_GO : ST_EXP;
						OP_CHK:  state_d = ST_CHK;
						default: state_d = ST_EXP;
					endcase
				end
			end
			ST_EXP: begin
				if (ecnt_q == '0) state_d = (x_q == NUM_ONE) ? ST_DONE : ST_CHK;
				else if (started_q) state_d = ST_GO;
			end
			ST_CHK: begin
				if (s_q == '0 || x_q == nm1) state_d = ST_DONE;
				else state_d = ST_GO;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req_ready = (state_q == ST_IDLE);
		mm_start  = (state_q == ST_GO);
		res.push  = (state_q == ST_DONE) && out_free;
		res.flag  = flag_q;
		case (op_q)
			OP_RED: begin
				mm_x = NUM_ONE;
				mm_y = a_q;
			end
			OP_MUL: begin
				mm_x = base_q;
				mm_y = x_q;
			end
			default: begin
				mm_x = x_q;
				mm_y = x_q;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q      <= OP_RED;
			started_q <= 1'b0;
			ecnt_q    <= '0;
			s_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						started_q <= 1'b0;
						ecnt_q    <= CNT_W'(NUM_WIDTH);
						s_q       <= '0;
						op_q      <= OP_RED;
					end
				end
				ST_TZ: begin
					if (!e_q[0]) s_q <= s_q + S_W'(1);
				end
				ST_WAIT: begin
					if (mm_stat.done) begin
						case (op_q)
							OP_SQ: begin
								if (e_q[NUM_WIDTH-1]) op_q <= OP_MUL;
								else ecnt_q <= ecnt_q - CNT_W'(1);
							end
							OP_MUL:  ecnt_q <= ecnt_q - CNT_W'(1);
							OP_CHK:  s_q <= s_q - S_W'(1);
							default: ;
						endcase
					end
				end
				ST_EXP: begin
					if (ecnt_q != '0) begin
						if (started_q) begin
							op_q <= OP_SQ;
						end else begin
							ecnt_q <= ecnt_q - CNT_W'(1);
							if (e_q[NUM_WIDTH-1]) started_q <= 1'b1;
						end
					end
				end
				ST_CHK: begin
					op_q <= OP_CHK;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					n_q    <= cand_n;
					e_q    <= cand_n - NUM_ONE;
					a_q    <= base[NUM_WIDTH-1:0];
					x_q    <= NUM_ONE;
					flag_q <= 1'b0;
				end
			end
			ST_TZ: begin
				if (!e_q[0]) e_q <= {1'b0, e_q[NUM_WIDTH-1:1]};
			end
			ST_WAIT: begin
				if (mm_stat.done) begin
					case (op_q)
						OP_RED: base_q <= mm_r;
						OP_SQ: begin
							x_q <= mm_r;
							if (!e_q[NUM_WIDTH-1]) e_q <= {e_q[NUM_WIDTH-2:0], 1'b0};
						end
						OP_MUL: begin
							x_q <= mm_r;
							e_q <= {e_q[NUM_WIDTH-2:0], 1'b0};
						end
						default: x_q <= mm_r;
					endcase
				end
			end
			ST_EXP: begin
				if (ecnt_q == '0) begin
					flag_q <= (x_q == NUM_ONE);
				end else if (!started_q) begin
					e_q <= {e_q[NUM_WIDTH-2:0], 1'b0};
					if (e_q[NUM_WIDTH-1]) x_q <= base_q;
				end
			end
			ST_CHK: begin
				flag_q <= (s_q != '0) && (x_q == nm1);
			end
			default: ;
		endcase
	end

	// the multiplier is never restarted while it works
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mm_start |-> !mm_stat.busy)
		else $error("multiplier started while busy");

	// multiply operands are reduced
	a_mul_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GO && op_q == OP_MUL) |-> (base_q < n_q) && (x_q < n_q))
		else $error("multiply operand not reduced");

	// only moduli of two or more reach the multiplier
	a_mod_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GO) |-> (n_q[NUM_WIDTH-1:1] != '0))
		else $error("multiplier run with modulus below two");

	// a verdict is pushed only from the done state and then the sequencer is free
	a_push_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res.push |=> (state_q == ST_IDLE))
		else $error("sequencer not idle after verdict");

endmodule

>>> rtl/strong_probable_prime_test.sv
// ----------------------------------------------------------------------------
// strong_probable_prime_test - strong probable prime test to a fixed base
// Writes n-1 as d * 2^s, computes base^d mod n and the squaring chain on a
// bit-serial modular multiplier; answers one flag per candidate.
//
//   port  dir  payload                 note
//   req   in   candidate[31:0]         number under test
//   rsp   out  probable_prime          one flag per request
//   cfg   in   witness_base[31:0]      base register, reset value 2
//
// Every modular product runs on the one shared multiplier; candidates
// of 0 or 1 answer false without a multiplier run.
// One request is worked at a time; the next is taken while the flag still
// waits in the output register. Base writes are taken at once.
// Reset sets the base register to 2 and empties the output register.
// ----------------------------------------------------------------------------
module strong_probable_prime_test
	import spp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	spp_cand_if.sink     req,
	spp_res_if.source    rsp,
	spp_cfg_if.sink      cfg
);

	logic [BASE_W-1:0] base_q;
	logic              rsp_valid_q;
	logic              rsp_flag_q;
	logic              out_free;
	spp_res_t          res;

	// base register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
		end else if (cfg.valid && cfg.ready) begin
			base_q <= cfg.witness_base;
		end
	end

	// sequencer and multiplier
	spp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.cand      (req.candidate),
		.base      (base_q),
		.out_free  (out_free),
		.res       (res)
	);

	// output register: hold the flag until taken
	assign out_free = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res.push) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.push) rsp_flag_q <= res.flag;
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.probable_prime = rsp_flag_q;

endmodule

>>> verif/tb_strong_probable_prime_test.sv
// ----------------------------------------------------------------------------
// tb_strong_probable_prime_test - self-checking bench of the SPRP tester
// Sends candidates under several witness bases (reset value, 0, 1, all ones,
// small and random). Each accepted request is predicted by a behavioural
// strong probable prime test. Each returned flag is compared in order with
// the oldest prediction. Both channels idle at random, with quiet stretches.
// ----------------------------------------------------------------------------
module tb_strong_probable_prime_test;
	import spp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_GAP      = 7;
	localparam int PHASE_ITEMS  = 34;
	localparam int TAIL_CYCLES  = 100;

	// verdicts predicted for accepted candidates, oldest first
	class verdict_board;
		logic [BASE_W-1:0] base_copy;
		bit                pending_verdicts[$];
		int unsigned       mismatches;
		int unsigned       seen_prime;
		int unsigned       seen_composite;

		function new();
			base_copy      = BASE_RESET;
			mismatches     = 0;
			seen_prime     = 0;
			seen_composite = 0;
		endfunction

		function void set_base(logic [BASE_W-1:0] value);
			base_copy = value;
		endfunction

		// Miller-Rabin round to one base, on 64-bit products
		function bit is_strong_prp(logic [63:0] n, logic [63:0] a);
			logic [63:0] d;
			logic [63:0] x;
			logic [63:0] b;
			logic [63:0] nm1;
			int          s;
			if (n < 64'd2)
				return 1'b0;
			nm1 = n - 64'd1;
			d   = nm1;
			s   = 0;
			while (d[0] == 1'b0) begin
				d = d >> 1;
				s++;
			end
			b = a % n;
			x = 64'd1 % n;
			while (d != 64'd0) begin
				if (d[0])
					x = (x * b) % n;
				b = (b * b) % n;
				d = d >> 1;
			end
			if (x == 64'd1)
				return 1'b1;
			while (s > 0) begin
				if (x == nm1)
					return 1'b1;
				x = (x * x) % n;
				s--;
			end
			return 1'b0;
		endfunction

		function void note_candidate(logic [CAND_W-1:0] cand);
			logic [63:0] mask;
			mask = (64'd1 << NUM_WIDTH) - 64'd1;
			pending_verdicts.push_back(
				is_strong_prp(64'(cand) & mask, 64'(base_copy) & mask));
		endfunction

		function void check_verdict(logic flag);
			bit want;
			if (pending_verdicts.size() == 0) begin
				$error("probable_prime: no request outstanding, actual %0b", flag);
				mismatches++;
				return;
			end
			want = pending_verdicts.pop_front();
			if (flag !== want) begin
				$error("probable_prime: expected %0b, actual %0b", want, flag);
				mismatches++;
			end
			if (flag === 1'b1)
				seen_prime++;
			else
				seen_composite++;
		endfunction

		function int pending();
			return pending_verdicts.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	spp_cand_if req ();
	spp_res_if  rsp ();
	spp_cfg_if  cfg ();

	strong_probable_prime_test u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source),
		.cfg    (cfg.sink)
	);

	verdict_board board;
	bit           steady;
	int unsigned  sent;
	int unsigned  phases;

	// corner values, known strong pseudoprimes and primes, reused by the random part
	logic [CAND_W-1:0] corner_cands [] = '{
		32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd15,
		32'd341, 32'd561, 32'd2047, 32'd3277, 32'd65537, 32'd1373653,
		32'd25326001, 32'd3215031751, 32'd4293001441, 32'd4294967291,
		32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF
	};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// offer one candidate after a random gap; valid is left high on accept
	task automatic send_candidate(input logic [CAND_W-1:0] cand);
		int gap;
		gap = steady ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid     <= 1'b1;
		req.candidate <= cand;
		do
			@(posedge clk);
		while (!req.ready);
		board.note_candidate(cand);
		sent++;
	endtask

	// drop the request and hold until every flag has come back
	task automatic drain();
		req.valid <= 1'b0;
		do
			@(posedge clk);
		while (board.pending() > 0);
	endtask

	task automatic write_base(input logic [BASE_W-1:0] value);
		cfg.valid        <= 1'b1;
		cfg.witness_base <= value;
		do
			@(posedge clk);
		while (!cfg.ready);
		cfg.valid <= 1'b0;
		board.set_base(value);
		phases++;
	endtask

	function automatic logic [CAND_W-1:0] pick_candidate();
		logic [CAND_W-1:0] r;
		r = $urandom();
		case ($urandom_range(0, 9))
			0, 1:    return r;
			2, 3, 4: return r | 32'd1;
			5:       return CAND_W'($urandom_range(0, 300));
			6:       return board.base_copy + CAND_W'($urandom_range(0, 2)) - 32'd1;
			7:       return 32'hFFFF_FFFF - CAND_W'($urandom_range(0, 64));
			8:       return {1'b1, r[30:1], 1'b1};
			default: return corner_cands[$urandom_range(0, corner_cands.size() - 1)];
		endcase
	endfunction

	task automatic random_phase(input int count);
		for (int i = 0; i < count; i++) begin
			if (i % 16 == 0)
				steady = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 24) == 0)
				drain();
			send_candidate(pick_candidate());
		end
		drain();
	endtask

	// response side: stall at random, check each accepted flag
	initial begin
		int stall;
		rsp.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do
				@(posedge clk);
			while (!(rsp.valid && rsp.ready));
			board.check_verdict(rsp.probable_prime);
		end
	end

	initial begin
		logic [BASE_W-1:0] bases [] = '{
			32'd0, 32'hFFFF_FFFF, 32'd1, 32'd3, 32'hFFFF_FFFE
		};
		board  = new();
		steady = 1'b0;
		sent   = 0;
		phases = 1;
		arst_n           <= 1'b0;
		req.valid        <= 1'b0;
		req.candidate    <= '0;
		cfg.valid        <= 1'b0;
		cfg.witness_base <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners under the reset base
		foreach (corner_cands[i])
			send_candidate(corner_cands[i]);
		random_phase(PHASE_ITEMS);

		// fixed extremes and a small base, then a random base, then back to two
		foreach (bases[i]) begin
			write_base(bases[i]);
			random_phase(PHASE_ITEMS);
		end
		write_base($urandom());
		random_phase(PHASE_ITEMS);
		write_base(BASE_RESET);
		foreach (corner_cands[i])
			send_candidate(corner_cands[i]);
		random_phase(PHASE_ITEMS / 2);

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Tested %0d candidates under %0d base settings.", sent, phases);
		$display("Flags seen: %0d probable prime, %0d composite, %0d mismatches.",
			board.seen_prime, board.seen_composite, board.mismatches);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// watchdog on a hung handshake
	initial begin
		#40ms;
		$display("Timeout with %0d flags outstanding.", board.pending());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
